>>> rtl/pgf_pkg.sv
// ============================================================================
// pgf_pkg
// Shared widths, register indexes and the item type for the pairwise
// gravity force block.
// ============================================================================
package pgf_pkg;

    localparam int COORD_W     = 32;
    localparam int MASS_W      = 32;
    localparam int DELTA_W     = 33;   // magnitude of a coordinate difference
    localparam int SUMSQ_W     = 66;   // dx^2 + dy^2
    localparam int LIMSQ_W     = 64;   // min_distance^2
    localparam int ROOT_W      = 33;   // floor(sqrt(sumsq))
    localparam int GM_W        = 64;   // G * m1
    localparam int PROD_W      = 96;   // G * m1 * m2
    localparam int PART_W      = 65;   // 32-bit limb of PROD times a delta
    localparam int HALFPROD_W  = 66;   // 33 x 33 partial product
    localparam int NUM_W       = 129;  // PROD * |delta|
    localparam int DEN_W       = 99;   // sumsq * root
    localparam int MAG_W       = 47;   // clamped quotient magnitude
    localparam int FORCE_W     = 48;
    localparam int IN_DATA_W   = 192;
    localparam int OUT_DATA_W  = 192;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int ROOT_STAGES = 33;
    localparam int DIV_LAT     = MAG_W + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF  = 8'd1;

    localparam logic [CFG_DATA_W-1:0] CUTOFF_RESET = 32'd327680;
    localparam logic [MAG_W-1:0]      MAG_MAX      = {MAG_W{1'b1}};

    // one classified item between front and back
    typedef struct packed {
        logic [DELTA_W-1:0] ax;
        logic [DELTA_W-1:0] ay;
        logic               sx;
        logic               sy;
        logic [MASS_W-1:0]  m1;
        logic [MASS_W-1:0]  m2;
        logic [SUMSQ_W-1:0] sumsq;
        logic               applied;
    } pgf_item_t;

    // sign and flag bits that ride along with the dividers
    typedef struct packed {
        logic sx;
        logic sy;
        logic applied;
    } pgf_tag_t;

endpackage

>>> rtl/pgf_front.sv
// ============================================================================
// pgf_front
// Takes in body pairs, forms the displacement and its squared length, and
// flags whether the pair lies beyond the minimum distance.
// ============================================================================
module pgf_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x, first_y, second_x, second_y, first_mass, second_mass
    input  logic [pgf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [pgf_pkg::CFG_DATA_W-1:0]   min_distance,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pgf_pkg::pgf_item_t               out_item
);
    import pgf_pkg::*;

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [DELTA_W-1:0]   dx, dy;
    logic [LIMSQ_W-1:0]   limsq_reg;
    pgf_item_t            s1_reg, s2_reg, s3_reg;
    logic [SUMSQ_W-1:0]   sqx_reg, sqy_reg;
    logic [SUMSQ_W-1:0]   sumsq;

    assign en       = !v3_reg || out_ready;
    assign s_tready = en;

    assign dx = {s_tdata[31], s_tdata[31:0]}   - {s_tdata[95], s_tdata[95:64]};
    assign dy = {s_tdata[63], s_tdata[63:32]}  - {s_tdata[127], s_tdata[127:96]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // squared threshold follows the register; the user must change it only while idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        limsq_reg <= LIMSQ_W'(min_distance) * LIMSQ_W'(min_distance);
    end

    assign sumsq = sqx_reg + sqy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.ax      <= dx[DELTA_W-1] ? (DELTA_W'(0) - dx) : dx;
            s1_reg.ay      <= dy[DELTA_W-1] ? (DELTA_W'(0) - dy) : dy;
            s1_reg.sx      <= dx[DELTA_W-1];
            s1_reg.sy      <= dy[DELTA_W-1];
            s1_reg.m1      <= s_tdata[159:128];
            s1_reg.m2      <= s_tdata[191:160];
            s1_reg.sumsq   <= '0;
            s1_reg.applied <= 1'b0;

            s2_reg  <= s1_reg;
            sqx_reg <= SUMSQ_W'(s1_reg.ax) * SUMSQ_W'(s1_reg.ax);
            sqy_reg <= SUMSQ_W'(s1_reg.ay) * SUMSQ_W'(s1_reg.ay);

            s3_reg.ax      <= s2_reg.ax;
            s3_reg.ay      <= s2_reg.ay;
            s3_reg.sx      <= s2_reg.sx;
            s3_reg.sy      <= s2_reg.sy;
            s3_reg.m1      <= s2_reg.m1;
            s3_reg.m2      <= s2_reg.m2;
            s3_reg.sumsq   <= sumsq;
            s3_reg.applied <= sumsq > SUMSQ_W'(limsq_reg);
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = s3_reg;

endmodule

>>> rtl/pgf_fifo.sv
// ============================================================================
// pgf_fifo
// Short queue of classified items between the front and the back.
// ============================================================================
module pgf_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  pgf_pkg::pgf_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output pgf_pkg::pgf_item_t  pop_item
);
    import pgf_pkg::*;

    pgf_item_t               mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]     count_reg;
    logic                    push, pop;

    assign push_ready = count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> rtl/pgf_div.sv
// ============================================================================
// pgf_div
// Pipelined restoring divider: one quotient bit per stage, with the
// quotient clamped to the largest force magnitude.
// ============================================================================
module pgf_div (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [pgf_pkg::NUM_W-1:0]    num,
    input  logic [pgf_pkg::DEN_W-1:0]    den,
    output logic [pgf_pkg::MAG_W-1:0]    mag
);
    import pgf_pkg::*;

    logic [DEN_W-1:0] r_reg   [0:MAG_W];
    logic [DEN_W-1:0] den_reg [0:MAG_W];
    logic [MAG_W-1:0] low_reg [0:MAG_W];
    logic [MAG_W-1:0] q_reg   [0:MAG_W];
    logic             sat_reg [0:MAG_W];
    logic [DEN_W-1:0] top;
    logic             sat;

    // quotient overflows 47 bits exactly when num >= den * 2^47
    assign top = DEN_W'(num[NUM_W-1:MAG_W]);
    assign sat = top >= den;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= sat ? '0 : top;
            den_reg[0] <= den;
            low_reg[0] <= num[MAG_W-1:0];
            q_reg[0]   <= '0;
            sat_reg[0] <= sat;
        end
    end

    for (genvar k = 0; k < MAG_W; k++) begin : g_bit
        localparam int BIT = MAG_W - 1 - k;
        logic [DEN_W:0] rs, diff;
        logic           ge;

        assign rs   = {r_reg[k], low_reg[k][BIT]};
        assign diff = rs - {1'b0, den_reg[k]};
        assign ge   = rs >= {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]   <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
                q_reg[k+1]   <= q_reg[k] | (MAG_W'(ge) << BIT);
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= low_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    assign mag = sat_reg[MAG_W] ? MAG_MAX : q_reg[MAG_W];

endmodule

>>> rtl/pgf_back.sv
// ============================================================================
// pgf_back
// Forms G*m1*m2, the integer root of the squared separation, numerators and
// denominator, divides per axis and drives the result register.
// ============================================================================
module pgf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pgf_pkg::pgf_item_t              in_item,
    input  logic [pgf_pkg::CFG_DATA_W-1:0]  gravity,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // force_two_x, force_two_y, force_one_x, force_one_y
    output logic [pgf_pkg::OUT_DATA_W-1:0]  m_tdata,
    // applied
    output logic                            m_tuser
);
    import pgf_pkg::*;

    logic                   en;
    logic                   p1_valid_reg, p2_valid_reg, p3_valid_reg;
    pgf_item_t              p1_item_reg, p2_item_reg, p3_item_reg;
    logic [GM_W-1:0]        gm_reg, ph_reg, pl_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic                   rt_valid_reg [1:ROOT_STAGES];
    logic [SUMSQ_W-1:0]     rt_rem_reg   [1:ROOT_STAGES];
    logic [ROOT_W-1:0]      rt_root_reg  [1:ROOT_STAGES];
    pgf_item_t              rt_item_reg  [1:ROOT_STAGES];
    logic [PROD_W-1:0]      rt_prod_reg  [1:ROOT_STAGES];

    pgf_item_t              lst_item;
    logic [ROOT_W-1:0]      lst_root;
    logic [PROD_W-1:0]      lst_prod;

    logic                   d1_valid_reg, d2_valid_reg;
    pgf_tag_t               d1_tag_reg, d2_tag_reg;
    logic [HALFPROD_W-1:0]  dh_reg, dl_reg;
    logic [PART_W-1:0]      nx_reg [0:2];
    logic [PART_W-1:0]      ny_reg [0:2];
    logic [DEN_W-1:0]       den_reg;
    logic [NUM_W-1:0]       numx_reg, numy_reg;

    logic                   tv_reg  [0:DIV_LAT-1];
    pgf_tag_t               tag_reg [0:DIV_LAT-1];
    logic [MAG_W-1:0]       magx, magy;
    logic [FORCE_W-1:0]     fx, fy;
    pgf_tag_t               tag_out;

    assign en       = !m_tvalid || m_tready;
    assign in_ready = en;

    // ---- G * m1 * m2 -------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_item_reg <= in_item;
            gm_reg      <= GM_W'(gravity) * GM_W'(in_item.m1);
            p2_item_reg <= p1_item_reg;
            ph_reg      <= GM_W'(gm_reg[63:32]) * GM_W'(p1_item_reg.m2);
            pl_reg      <= GM_W'(gm_reg[31:0]) * GM_W'(p1_item_reg.m2);
            p3_item_reg <= p2_item_reg;
            prod_reg    <= (PROD_W'(ph_reg) << 32) + PROD_W'(pl_reg);
        end
    end

    // ---- integer square root, one root bit per stage ---------------------
    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
        localparam int BIT = ROOT_STAGES - 1 - k;
        logic                 src_valid;
        logic [SUMSQ_W-1:0]   src_rem;
        logic [ROOT_W-1:0]    src_root;
        pgf_item_t            src_item;
        logic [PROD_W-1:0]    src_prod;
        logic [SUMSQ_W+1:0]   rem_ext, trial;

        if (k == 0) begin : g_src
            assign src_valid = p3_valid_reg;
            assign src_rem   = p3_item_reg.sumsq;
            assign src_root  = '0;
            assign src_item  = p3_item_reg;
            assign src_prod  = prod_reg;
        end else begin : g_src
            assign src_valid = rt_valid_reg[k];
            assign src_rem   = rt_rem_reg[k];
            assign src_root  = rt_root_reg[k];
            assign src_item  = rt_item_reg[k];
            assign src_prod  = rt_prod_reg[k];
        end

        // rem = S - root^2; try setting this bit: (2*root + 2^bit) * 2^bit
        assign rem_ext = {2'b00, src_rem};
        assign trial   = ((SUMSQ_W+2)'(src_root) << (BIT + 1))
                       + ((SUMSQ_W+2)'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                rt_valid_reg[k+1] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_ext >= trial) begin
                    rt_rem_reg[k+1]  <= SUMSQ_W'(rem_ext - trial);
                    rt_root_reg[k+1] <= src_root | (ROOT_W'(1) << BIT);
                end else begin
                    rt_rem_reg[k+1]  <= src_rem;
                    rt_root_reg[k+1] <= src_root;
                end
                rt_item_reg[k+1] <= src_item;
                rt_prod_reg[k+1] <= src_prod;
            end
        end
    end

    assign lst_item = rt_item_reg[ROOT_STAGES];
    assign lst_root = rt_root_reg[ROOT_STAGES];
    assign lst_prod = rt_prod_reg[ROOT_STAGES];

    // ---- denominator S*R and numerators P*|d| -------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
        end else if (en) begin
            d1_valid_reg <= rt_valid_reg[ROOT_STAGES];
            d2_valid_reg <= d1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_tag_reg.sx      <= lst_item.sx;
            d1_tag_reg.sy      <= lst_item.sy;
            d1_tag_reg.applied <= lst_item.applied;
            dh_reg <= HALFPROD_W'(lst_item.sumsq[65:33]) * HALFPROD_W'(lst_root);
            dl_reg <= HALFPROD_W'(lst_item.sumsq[32:0])  * HALFPROD_W'(lst_root);
            for (int i = 0; i < 3; i++) begin
                nx_reg[i] <= PART_W'(lst_prod[32*i +: 32]) * PART_W'(lst_item.ax);
                ny_reg[i] <= PART_W'(lst_prod[32*i +: 32]) * PART_W'(lst_item.ay);
            end

            d2_tag_reg <= d1_tag_reg;
            den_reg    <= (DEN_W'(dh_reg) << 33) + DEN_W'(dl_reg);
            numx_reg   <= NUM_W'(nx_reg[0]) + (NUM_W'(nx_reg[1]) << 32)
                        + (NUM_W'(nx_reg[2]) << 64);
            numy_reg   <= NUM_W'(ny_reg[0]) + (NUM_W'(ny_reg[1]) << 32)
                        + (NUM_W'(ny_reg[2]) << 64);
        end
    end

    // ---- per-axis dividers, tags delayed to match -------------------------
    pgf_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (numx_reg),
        .den  (den_reg),
        .mag  (magx)
    );

    pgf_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (numy_reg),
        .den  (den_reg),
        .mag  (magy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) tv_reg[i] <= 1'b0;
        end else if (en) begin
            tv_reg[0] <= d2_valid_reg;
            for (int i = 1; i < DIV_LAT; i++) tv_reg[i] <= tv_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= d2_tag_reg;
            for (int i = 1; i < DIV_LAT; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    // ---- sign, zeroing and result register ------------------------------
    assign tag_out = tag_reg[DIV_LAT-1];
    assign fx = !tag_out.applied ? '0 :
                tag_out.sx ? (FORCE_W'(0) - FORCE_W'(magx)) : FORCE_W'(magx);
    assign fy = !tag_out.applied ? '0 :
                tag_out.sy ? (FORCE_W'(0) - FORCE_W'(magy)) : FORCE_W'(magy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= tv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {FORCE_W'(0) - fy, FORCE_W'(0) - fx, fy, fx};
            m_tuser <= tag_out.applied;
        end
    end

endmodule

>>> rtl/pairwise_gravity_force.sv
// Stages: an accepted item passes through 3 front stages, the queue,
//   3 mass-product, 33 root, 2 product, 48 divider stages and the result
//   register before its result appears on m_tvalid.
// Throughput: one item per cycle while m_tready does not stall the output; every unit is fully pipelined.
// Reset: synchronous, active low; clears the pipeline and queue, G to 0 and
//   the minimum distance to 5.0.
// ============================================================================
// pairwise_gravity_force
// Newtonian attraction between two bodies in the plane, fixed point.
// ============================================================================
module pairwise_gravity_force (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x, first_y, second_x, second_y, first_mass, second_mass
    input  logic [pgf_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // force_two_x, force_two_y, force_one_x, force_one_y
    output logic [pgf_pkg::OUT_DATA_W-1:0]   m_tdata,
    // applied
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pgf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pgf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pgf_pkg::*;

    logic [CFG_DATA_W-1:0] gravity_reg, cutoff_reg;
    logic                  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    pgf_item_t             q_push_item, q_pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= '0;
            cutoff_reg  <= CUTOFF_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_GRAVITY) gravity_reg <= cfg_data;
            if (cfg_index == REG_CUTOFF)  cutoff_reg  <= cfg_data;
        end
    end

    pgf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .min_distance (cutoff_reg),
        .out_valid    (q_push_valid),
        .out_ready    (q_push_ready),
        .out_item     (q_push_item)
    );

    pgf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    pgf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_pop_valid),
        .in_ready (q_pop_ready),
        .in_item  (q_pop_item),
        .gravity  (gravity_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
